>>> hdl/cawt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cawt_pkg
// Shared types, route codes and the fixed region table of the chip address
// window translator.
// ----------------------------------------------------------------------------
package cawt_pkg;

  // route codes
  typedef logic [1:0] route_t;
  localparam route_t ROUTE_DIRECT = 2'd0;
  localparam route_t ROUTE_SLOT   = 2'd1;
  localparam route_t ROUTE_L1     = 2'd2;
  localparam route_t ROUTE_L2     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_L1_MASK   = 2'd0;
  localparam logic [1:0] CFG_L1_WINDOW = 2'd1;
  localparam logic [1:0] CFG_L2_ADDR   = 2'd2;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned OFFSET_W = 26;
  localparam int unsigned WINDOW_W = 21;
  localparam int unsigned SLOT_W   = 21;
  localparam int unsigned SPAN_W   = 26;

  localparam logic [ADDR_W-1:0] DIRECT_LIMIT = 32'h0020_0000;

  // queue between classifier and executor
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // fixed region table
  localparam int unsigned TABLE_ROWS = 51;

  localparam logic [ADDR_W-1:0] REGION_CHIP [TABLE_ROWS] = '{
    32'h830c0000, 32'h54000000, 32'h55000000, 32'h56000000, 32'h57000000,
    32'h58000000, 32'h59000000, 32'h820c0000, 32'h820c8000, 32'h820cc000,
    32'h74030000, 32'h820e0000, 32'h820e1000, 32'h820e2000, 32'h820e3000,
    32'h820e4000, 32'h820e5000, 32'h820ce000, 32'h820e7000, 32'h820cf000,
    32'h820e9000, 32'h820ea000, 32'h820eb000, 32'h820ec000, 32'h820ed000,
    32'h820ca000, 32'h820d0000, 32'h40000000, 32'h00400000, 32'h00410000,
    32'h820f0000, 32'h820f1000, 32'h820f2000, 32'h820f3000, 32'h820f4000,
    32'h820f5000, 32'h820f7000, 32'h820f9000, 32'h820fa000, 32'h820fb000,
    32'h820fc000, 32'h820fd000, 32'h820c4000, 32'h820b0000, 32'h80020000,
    32'h81020000, 32'h7c020000, 32'h7c060000, 32'h7c000000, 32'h70020000,
    32'h7c500000
  };

  localparam logic [SLOT_W-1:0] REGION_SLOT [TABLE_ROWS] = '{
    21'h000000, 21'h002000, 21'h003000, 21'h004000, 21'h005000,
    21'h006000, 21'h007000, 21'h008000, 21'h00c000, 21'h00e000,
    21'h010000, 21'h020000, 21'h020400, 21'h020800, 21'h020c00,
    21'h021000, 21'h021400, 21'h021c00, 21'h021e00, 21'h022000,
    21'h023400, 21'h024000, 21'h024200, 21'h024600, 21'h024800,
    21'h026000, 21'h030000, 21'h070000, 21'h080000, 21'h090000,
    21'h0a0000, 21'h0a0600, 21'h0a0800, 21'h0a0c00, 21'h0a1000,
    21'h0a1400, 21'h0a1e00, 21'h0a3400, 21'h0a4000, 21'h0a4200,
    21'h0a4600, 21'h0a4800, 21'h0a8000, 21'h0ae000, 21'h0b0000,
    21'h0c0000, 21'h0d0000, 21'h0e0000, 21'h0f0000, 21'h1f0000,
    21'h060000
  };

  localparam logic [SPAN_W-1:0] REGION_SPAN [TABLE_ROWS] = '{
    26'h0001000, 26'h0001000, 26'h0001000, 26'h0001000, 26'h0001000,
    26'h0001000, 26'h0001000, 26'h0004000, 26'h0002000, 26'h0002000,
    26'h0001000, 26'h0000400, 26'h0000200, 26'h0000400, 26'h0000400,
    26'h0000400, 26'h0000800, 26'h0000200, 26'h0000200, 26'h0001000,
    26'h0000200, 26'h0000200, 26'h0000400, 26'h0000200, 26'h0000800,
    26'h0002000, 26'h0010000, 26'h0010000, 26'h0010000, 26'h0010000,
    26'h0000400, 26'h0000200, 26'h0000400, 26'h0000400, 26'h0000400,
    26'h0000800, 26'h0000200, 26'h0000200, 26'h0000200, 26'h0000400,
    26'h0000200, 26'h0000800, 26'h0004000, 26'h0001000, 26'h0010000,
    26'h0010000, 26'h0010000, 26'h0010000, 26'h0010000, 26'h0010000,
    26'h2000000
  };

  // classified transaction handed from front to back
  typedef struct packed {
    route_t              kind;
    logic [OFFSET_W-1:0] slot_off;
    logic [ADDR_W-1:0]   addr;
  } cawt_item_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [ADDR_W-1:0]   l1_mask;
    logic [WINDOW_W-1:0] l1_window;
    logic [ADDR_W-1:0]   l2_addr;
  } cawt_cfg_t;

  // replace the masked base field of a remap value by src[31:16]
  function automatic logic [ADDR_W-1:0] with_base(
    input logic [ADDR_W-1:0] reg_val,
    input logic [ADDR_W-1:0] src,
    input logic [ADDR_W-1:0] mask
  );
    logic [ADDR_W-1:0] hi;
    hi = {src[31:16], 16'h0000};
    return (reg_val & ~mask) | (hi & mask);
  endfunction

endpackage

>>> hdl/cawt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cawt_front
// Accepts chip addresses, sorts them into direct, fixed slot, L1 band or L2
// route and resolves the slot offset through a parallel region search.
// ----------------------------------------------------------------------------
module cawt_front
  import cawt_pkg::*;
#(
  parameter int unsigned FIXED_SLOTS = 51
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ADDR_W-1:0] chip_address,
  input  logic              q_full,
  output logic              push,
  output cawt_item_t        push_item
);

  localparam int unsigned ROWS = (FIXED_SLOTS < TABLE_ROWS) ? FIXED_SLOTS : TABLE_ROWS;

  logic [ADDR_W-1:0]   diff [ROWS];
  logic [ROWS-1:0]     hit;
  logic                any_hit;
  logic [SLOT_W-1:0]   sel_slot;
  logic [SPAN_W-1:0]   sel_diff;
  logic                in_l1_band;

  // handshake: take a transaction whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // per-region bound checks, all in parallel
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      diff[i] = chip_address - REGION_CHIP[i];
      hit[i]  = (chip_address >= REGION_CHIP[i]) &&
                (diff[i][ADDR_W-1:SPAN_W] == '0) &&
                (diff[i][SPAN_W-1:0] < REGION_SPAN[i]);
    end
  end

  // first matching region wins
  always_comb begin
    sel_slot = '0;
    sel_diff = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel_slot = REGION_SLOT[i];
        sel_diff = diff[i][SPAN_W-1:0];
      end
    end
  end

  assign any_hit = |hit;

  // address bands reached through the L1 window
  assign in_l1_band =
    (chip_address >= 32'h1800_0000 && chip_address < 32'h18c0_0000) ||
    (chip_address >= 32'h7000_0000 && chip_address < 32'h7800_0000) ||
    (chip_address >= 32'h7c00_0000 && chip_address < 32'h7c40_0000);

  // route classification
  always_comb begin
    push_item.addr     = chip_address;
    push_item.slot_off = OFFSET_W'({{(OFFSET_W-SLOT_W){1'b0}}, sel_slot} + sel_diff);
    if (chip_address < DIRECT_LIMIT) begin
      push_item.kind = ROUTE_DIRECT;
    end else if (any_hit) begin
      push_item.kind = ROUTE_SLOT;
    end else if (in_l1_band) begin
      push_item.kind = ROUTE_L1;
    end else begin
      push_item.kind = ROUTE_L2;
    end
  end

endmodule

>>> hdl/cawt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cawt_queue
// Short FIFO of classified transactions between front and back end.
// ----------------------------------------------------------------------------
module cawt_queue
  import cawt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cawt_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       q_valid,
  output cawt_item_t head
);

  cawt_item_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // queue never overflows or underflows
  assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QDEPTH))
    else $error("queue count past depth");
  assert property (@(posedge clk) disable iff (rst) (pop |-> q_valid) and (push |-> !full))
    else $error("queue push while full or pop while empty");

endmodule

>>> hdl/cawt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cawt_back
// Executes classified transactions: restores saved remap values, programs
// the L1 and L2 remap registers and registers the result.
// ----------------------------------------------------------------------------
module cawt_back
  import cawt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cawt_cfg_t           cfg,
  input  logic                q_valid,
  input  cawt_item_t          head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OFFSET_W-1:0] bar_offset,
  output route_t              route_kind,
  output logic [ADDR_W-1:0]   l1_remap_value,
  output logic [ADDR_W-1:0]   l2_remap_value
);

  logic [ADDR_W-1:0]   l1_remap;
  logic [ADDR_W-1:0]   l2_remap;
  logic [ADDR_W-1:0]   l1_saved;
  logic [ADDR_W-1:0]   l2_saved;
  logic [ADDR_W-1:0]   l1_remap_next;
  logic [ADDR_W-1:0]   l2_remap_next;
  logic [ADDR_W-1:0]   l1_saved_next;
  logic [ADDR_W-1:0]   l2_saved_next;
  logic [ADDR_W-1:0]   l1_cur;
  logic [ADDR_W-1:0]   l2_cur;
  logic [OFFSET_W-1:0] off_next;

  // take the next transaction when the output register is free or draining
  assign pop = q_valid && (!out_valid || !out_stall);

  // values after the restore step
  assign l1_cur = (l1_saved != '0) ? l1_saved : l1_remap;
  assign l2_cur = (l2_saved != '0) ? l2_saved : l2_remap;

  // remap register update per route
  always_comb begin
    l1_remap_next = l1_remap;
    l2_remap_next = l2_remap;
    l1_saved_next = l1_saved;
    l2_saved_next = l2_saved;
    off_next      = '0;
    unique case (head.kind)
      ROUTE_DIRECT: begin
        off_next = {{(OFFSET_W-WINDOW_W){1'b0}}, head.addr[WINDOW_W-1:0]};
      end
      ROUTE_SLOT: begin
        l1_remap_next = l1_cur;
        l2_remap_next = l2_cur;
        l1_saved_next = '0;
        l2_saved_next = '0;
        off_next      = head.slot_off;
      end
      ROUTE_L1: begin
        l1_saved_next = l1_cur;
        l1_remap_next = with_base(l1_cur, head.addr, cfg.l1_mask);
        l2_remap_next = l2_cur;
        l2_saved_next = '0;
        off_next      = OFFSET_W'({{(OFFSET_W-WINDOW_W){1'b0}}, cfg.l1_window} +
                        {{(OFFSET_W-16){1'b0}}, head.addr[15:0]});
      end
      ROUTE_L2: begin
        l2_saved_next = l2_cur;
        l1_saved_next = '0;
        l1_remap_next = with_base(l1_cur, cfg.l2_addr, cfg.l1_mask);
        l2_remap_next = head.addr;
        off_next      = {{(OFFSET_W-WINDOW_W){1'b0}}, cfg.l1_window};
      end
      default: begin
        off_next = '0;
      end
    endcase
  end

  // remap state
  always_ff @(posedge clk) begin
    if (rst) begin
      l1_remap <= '0;
      l2_remap <= '0;
      l1_saved <= '0;
      l2_saved <= '0;
    end else if (pop) begin
      l1_remap <= l1_remap_next;
      l2_remap <= l2_remap_next;
      l1_saved <= l1_saved_next;
      l2_saved <= l2_saved_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      bar_offset     <= off_next;
      route_kind     <= head.kind;
      l1_remap_value <= l1_remap_next;
      l2_remap_value <= l2_remap_next;
    end
  end

  // direct route stays below the direct limit
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && route_kind == ROUTE_DIRECT) |-> bar_offset[OFFSET_W-1:WINDOW_W] == '0)
    else $error("direct offset out of range");

  // a slot hit leaves nothing saved
  assert property (@(posedge clk) disable iff (rst)
    (pop && head.kind == ROUTE_SLOT) |=> (l1_saved == '0 && l2_saved == '0))
    else $error("saved remap left after slot hit");

  // reported remap values match the live registers
  assert property (@(posedge clk) disable iff (rst)
    pop |=> (l1_remap_value == l1_remap && l2_remap_value == l2_remap))
    else $error("reported remap values differ from state");

endmodule

>>> hdl/chip_address_window_translator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip_address_window_translator
// Translates chip addresses into BAR offsets through direct, fixed slot,
// L1 window or L2 window routes, tracking the remap registers.
// ----------------------------------------------------------------------------
// an accepted transaction is written into the queue, then into the output register when popped
// throughput: one transaction per cycle unless stalled; the region search runs in the accepting
//   cycle ahead of the queue write and the remap update at the output register load
// a two-entry queue parts the front from the back end
// reset clears remap state, queue and output valid; config returns to defaults
module chip_address_window_translator
  import cawt_pkg::*;
#(
  parameter int unsigned FIXED_SLOTS = 51
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ADDR_W-1:0]   chip_address,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OFFSET_W-1:0] bar_offset,
  output logic [1:0]          route_kind,
  output logic [ADDR_W-1:0]   l1_remap_value,
  output logic [ADDR_W-1:0]   l2_remap_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [ADDR_W-1:0]   cfg_data
);

  cawt_cfg_t  cfg;
  cawt_item_t push_item;
  cawt_item_t head;
  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.l1_mask   <= 32'hFFFF_0000;
      cfg.l1_window <= 21'h13_0000;
      cfg.l2_addr   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_L1_MASK:   cfg.l1_mask   <= cfg_data;
        CFG_L1_WINDOW: cfg.l1_window <= cfg_data[WINDOW_W-1:0];
        CFG_L2_ADDR:   cfg.l2_addr   <= cfg_data;
        default: ;
      endcase
    end
  end

  // classifier
  cawt_front #(
    .FIXED_SLOTS (FIXED_SLOTS)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .chip_address (chip_address),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  // decoupling queue
  cawt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  // executor
  cawt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bar_offset     (bar_offset),
    .route_kind     (route_kind),
    .l1_remap_value (l1_remap_value),
    .l2_remap_value (l2_remap_value)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chip address window translator. A queue of
// addresses feeds a clocked driver; every accepted address is run through a
// behavioral translator kept in the bench, and a clocked monitor compares
// each output transaction field by field with the oldest expected one.
// Phases with different window settings are separated by drain pauses.
// ----------------------------------------------------------------------------
module tb_top;
  import cawt_pkg::*;

  localparam int unsigned REGION_COUNT = 51;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_ITEMS  = 204;

  // fixed region map: chip base, slot base and span of each region, in search order
  localparam logic [31:0] MAP_CHIP [REGION_COUNT] = '{
    32'h830c0000, 32'h54000000, 32'h55000000, 32'h56000000, 32'h57000000,
    32'h58000000, 32'h59000000, 32'h820c0000, 32'h820c8000, 32'h820cc000,
    32'h74030000, 32'h820e0000, 32'h820e1000, 32'h820e2000, 32'h820e3000,
    32'h820e4000, 32'h820e5000, 32'h820ce000, 32'h820e7000, 32'h820cf000,
    32'h820e9000, 32'h820ea000, 32'h820eb000, 32'h820ec000, 32'h820ed000,
    32'h820ca000, 32'h820d0000, 32'h40000000, 32'h00400000, 32'h00410000,
    32'h820f0000, 32'h820f1000, 32'h820f2000, 32'h820f3000, 32'h820f4000,
    32'h820f5000, 32'h820f7000, 32'h820f9000, 32'h820fa000, 32'h820fb000,
    32'h820fc000, 32'h820fd000, 32'h820c4000, 32'h820b0000, 32'h80020000,
    32'h81020000, 32'h7c020000, 32'h7c060000, 32'h7c000000, 32'h70020000,
    32'h7c500000
  };

  localparam logic [31:0] MAP_SLOT [REGION_COUNT] = '{
    32'h000000, 32'h002000, 32'h003000, 32'h004000, 32'h005000,
    32'h006000, 32'h007000, 32'h008000, 32'h00c000, 32'h00e000,
    32'h010000, 32'h020000, 32'h020400, 32'h020800, 32'h020c00,
    32'h021000, 32'h021400, 32'h021c00, 32'h021e00, 32'h022000,
    32'h023400, 32'h024000, 32'h024200, 32'h024600, 32'h024800,
    32'h026000, 32'h030000, 32'h070000, 32'h080000, 32'h090000,
    32'h0a0000, 32'h0a0600, 32'h0a0800, 32'h0a0c00, 32'h0a1000,
    32'h0a1400, 32'h0a1e00, 32'h0a3400, 32'h0a4000, 32'h0a4200,
    32'h0a4600, 32'h0a4800, 32'h0a8000, 32'h0ae000, 32'h0b0000,
    32'h0c0000, 32'h0d0000, 32'h0e0000, 32'h0f0000, 32'h1f0000,
    32'h060000
  };

  localparam logic [31:0] MAP_SPAN [REGION_COUNT] = '{
    32'h0001000, 32'h0001000, 32'h0001000, 32'h0001000, 32'h0001000,
    32'h0001000, 32'h0001000, 32'h0004000, 32'h0002000, 32'h0002000,
    32'h0001000, 32'h0000400, 32'h0000200, 32'h0000400, 32'h0000400,
    32'h0000400, 32'h0000800, 32'h0000200, 32'h0000200, 32'h0001000,
    32'h0000200, 32'h0000200, 32'h0000400, 32'h0000200, 32'h0000800,
    32'h0002000, 32'h0010000, 32'h0010000, 32'h0010000, 32'h0010000,
    32'h0000400, 32'h0000200, 32'h0000400, 32'h0000400, 32'h0000400,
    32'h0000800, 32'h0000200, 32'h0000200, 32'h0000200, 32'h0000400,
    32'h0000200, 32'h0000800, 32'h0004000, 32'h0001000, 32'h0010000,
    32'h0010000, 32'h0010000, 32'h0010000, 32'h0010000, 32'h0010000,
    32'h2000000
  };

  // one expected translation
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    route_t              kind;
    logic [ADDR_W-1:0]   l1;
    logic [ADDR_W-1:0]   l2;
  } translation_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ADDR_W-1:0]   chip_address = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OFFSET_W-1:0] bar_offset;
  logic [1:0]          route_kind;
  logic [ADDR_W-1:0]   l1_remap_value;
  logic [ADDR_W-1:0]   l2_remap_value;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = CFG_L1_MASK;
  logic [ADDR_W-1:0]   cfg_data = '0;

  // bench copy of the window settings and remap state
  logic [ADDR_W-1:0]   win_mask = 32'hFFFF_0000;
  logic [WINDOW_W-1:0] win_offset = 21'h13_0000;
  logic [ADDR_W-1:0]   l2_win_addr = '0;
  logic [ADDR_W-1:0]   l1_remap = '0;
  logic [ADDR_W-1:0]   l2_remap = '0;
  logic [ADDR_W-1:0]   l1_restore = '0;
  logic [ADDR_W-1:0]   l2_restore = '0;

  logic [ADDR_W-1:0]   address_backlog [$];
  translation_t        expected_translations [$];

  int unsigned mismatch_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned recv_cycles = 0;
  int unsigned idle_cycles = 0;
  logic        calm = 1'b0;
  logic        next_valid;

  chip_address_window_translator dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .chip_address   (chip_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bar_offset     (bar_offset),
    .route_kind     (route_kind),
    .l1_remap_value (l1_remap_value),
    .l2_remap_value (l2_remap_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  // random idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic in_l1_band(input logic [ADDR_W-1:0] a);
    return (a >= 32'h1800_0000 && a < 32'h18c0_0000) ||
           (a >= 32'h7000_0000 && a < 32'h7800_0000) ||
           (a >= 32'h7c00_0000 && a < 32'h7c40_0000);
  endfunction

  // swap the masked block base field of a remap value for src[31:16]
  function automatic logic [ADDR_W-1:0] merge_base(input logic [ADDR_W-1:0] r,
                                                   input logic [ADDR_W-1:0] src);
    return (r & ~win_mask) | (src & 32'hFFFF_0000 & win_mask);
  endfunction

  // translate one address, update the remap state, queue the expected result
  task automatic predict_translation(input logic [ADDR_W-1:0] a);
    translation_t t;
    logic         found;
    logic [31:0]  rel;
    logic [31:0]  sum;
    t = '0;
    found = 1'b0;
    if (a < 32'h0020_0000) begin
      t.offset = a[OFFSET_W-1:0];
      t.kind = ROUTE_DIRECT;
    end else begin
      // saved values go back first; zero means nothing saved
      if (l1_restore != 0) begin
        l1_remap = l1_restore;
        l1_restore = '0;
      end
      if (l2_restore != 0) begin
        l2_remap = l2_restore;
        l2_restore = '0;
      end
      for (int i = 0; i < REGION_COUNT && !found; i++) begin
        rel = a - MAP_CHIP[i];
        if (a >= MAP_CHIP[i] && rel < MAP_SPAN[i]) begin
          sum = MAP_SLOT[i] + rel;
          t.offset = sum[OFFSET_W-1:0];
          t.kind = ROUTE_SLOT;
          found = 1'b1;
        end
      end
      if (!found) begin
        if (in_l1_band(a)) begin
          l1_restore = l1_remap;
          l1_remap = merge_base(l1_remap, a);
          sum = 32'(win_offset) + 32'(a[15:0]);
          t.offset = sum[OFFSET_W-1:0];
          t.kind = ROUTE_L1;
        end else begin
          l2_restore = l2_remap;
          l1_remap = merge_base(l1_remap, l2_win_addr);
          l2_remap = a;
          t.offset = OFFSET_W'(win_offset);
          t.kind = ROUTE_L2;
        end
      end
    end
    t.l1 = l1_remap;
    t.l2 = l2_remap;
    expected_translations.push_back(t);
  endtask

  // random address: direct, region hits and edges, window bands, anything
  function automatic logic [ADDR_W-1:0] random_address();
    int unsigned r;
    int unsigned i;
    logic [31:0] lo;
    logic [31:0] hi;
    r = $urandom_range(0, 99);
    if (r < 12) return $urandom_range(0, 32'h1F_FFFF);
    if (r < 42) begin
      i = $urandom_range(0, REGION_COUNT - 1);
      case ($urandom_range(0, 5))
        0: return MAP_CHIP[i];
        1: return MAP_CHIP[i] + MAP_SPAN[i] - 1;
        2: return MAP_CHIP[i] + MAP_SPAN[i];
        default: return MAP_CHIP[i] + $urandom_range(0, MAP_SPAN[i] - 1);
      endcase
    end
    if (r < 67) begin
      case ($urandom_range(0, 2))
        0: begin lo = 32'h1800_0000; hi = 32'h18c0_0000; end
        1: begin lo = 32'h7000_0000; hi = 32'h7800_0000; end
        default: begin lo = 32'h7c00_0000; hi = 32'h7c40_0000; end
      endcase
      case ($urandom_range(0, 7))
        0: return lo;
        1: return hi - 1;
        2: return hi;
        3: return lo - 1;
        default: return lo + $urandom_range(0, hi - lo - 1);
      endcase
    end
    return $urandom();
  endfunction

  // one configuration write, bench copy updated on the accepting edge
  task automatic write_cfg(input logic [1:0] idx, input logic [ADDR_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_L1_MASK:   win_mask = val;
      CFG_L1_WINDOW: win_offset = val[WINDOW_W-1:0];
      CFG_L2_ADDR:   l2_win_addr = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // wait until all queued addresses went in and every result came back
  task automatic wait_drained();
    do @(posedge clk);
    while (address_backlog.size() != 0 || in_valid || expected_translations.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input logic [ADDR_W-1:0] exp_val,
                               input logic [ADDR_W-1:0] got_val);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch %s: expected %h got %h", what, exp_val, got_val);
  endtask

  // driver: hold the address until taken, then idle for a random gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        predict_translation(chip_address);
        next_valid = 1'b0;
        send_gap = pick_gap();
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (address_backlog.size() != 0) begin
          chip_address <= address_backlog.pop_front();
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // receiver stall: random gaps plus a long hold every so often
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      recv_cycles = 0;
    end else begin
      recv_cycles++;
      if (recv_cycles % 1200 == 600) hold_left = 60;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // monitor: compare each output transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_translations.size() == 0) begin
        note_mismatch("unexpected result", '0, 32'(bar_offset));
      end else begin
        translation_t t;
        t = expected_translations.pop_front();
        if (bar_offset !== t.offset) note_mismatch("bar_offset", 32'(t.offset), 32'(bar_offset));
        if (route_kind !== t.kind) note_mismatch("route_kind", 32'(t.kind), 32'(route_kind));
        if (l1_remap_value !== t.l1) note_mismatch("l1_remap_value", t.l1, l1_remap_value);
        if (l2_remap_value !== t.l2) note_mismatch("l2_remap_value", t.l2, l2_remap_value);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // stimulus phases
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: route boundaries, restore order, direct route between windows
    @(negedge clk);
    address_backlog = '{
      32'h0000_0000, 32'h0000_0000, 32'h1800_0000, 32'h001F_FFFF, 32'h830c_0000,
      32'h830c_0FFF, 32'h830c_1000, 32'h0020_0000, 32'h18BF_FFFF, 32'h18C0_0000,
      32'h7000_0000, 32'h7002_0005, 32'h77FF_FFFF, 32'h7c00_0000, 32'h7c01_0000,
      32'h7c3F_FFFF, 32'h7c40_0000, 32'h7c50_0000, 32'h7E4F_FFFF, 32'h7E50_0000,
      32'hFFFF_FFFF, 32'h820d_0000, 32'h0040_0000, 32'h820e_1200
    };

    for (int p = 1; p <= PHASES; p++) begin
      wait_drained();
      if (p == 1) begin
        write_cfg(CFG_L1_MASK, 32'hFFFF_FFFF);
        write_cfg(CFG_L1_WINDOW, 32'h001F_FFFF);
        write_cfg(CFG_L2_ADDR, 32'hFFFF_FFFF);
      end else if (p == 2) begin
        write_cfg(CFG_L1_MASK, 32'h0000_0000);
        write_cfg(CFG_L1_WINDOW, 32'h0000_0000);
        write_cfg(CFG_L2_ADDR, 32'h0000_0000);
      end else begin
        case ($urandom_range(0, 3))
          0: write_cfg(CFG_L1_MASK, 32'h0000_0000);
          1: write_cfg(CFG_L1_MASK, 32'hFFFF_FFFF);
          2: write_cfg(CFG_L1_MASK, 32'hFFFF_0000);
          default: write_cfg(CFG_L1_MASK, $urandom());
        endcase
        case ($urandom_range(0, 3))
          0: write_cfg(CFG_L1_WINDOW, 32'h0000_0000);
          1: write_cfg(CFG_L1_WINDOW, 32'h001F_FFFF);
          2: write_cfg(CFG_L1_WINDOW, 32'h0013_0000);
          default: write_cfg(CFG_L1_WINDOW, $urandom_range(0, 32'h1F_FFFF));
        endcase
        case ($urandom_range(0, 3))
          0: write_cfg(CFG_L2_ADDR, 32'h0000_0000);
          1: write_cfg(CFG_L2_ADDR, 32'hFFFF_FFFF);
          2: write_cfg(CFG_L2_ADDR, {16'($urandom_range(0, 16'hFFFF)), 16'h0000});
          default: write_cfg(CFG_L2_ADDR, $urandom());
        endcase
      end
      @(negedge clk);
      calm = (p == 3 || p == 6);
      for (int n = 0; n < PHASE_ITEMS; n++)
        address_backlog.push_back(random_address());
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0 && expected_translations.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
